// ----- hw/rtl/linear_move_interpolator_top_assert.svh -----
// Assertion macros used by the checker file of the move interpolator.
// Needs a clk and an rst_n signal in the scope where a macro is used.
`ifndef LINEAR_MOVE_INTERPOLATOR_TOP_ASSERT_SVH
`define LINEAR_MOVE_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LMI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lmi_pkg.sv -----
// Shared constants of the linear move interpolator: sizes, mode codes and
// register indexes. No dependencies.
`default_nettype none
package lmi_pkg;
  localparam int COMMAND_DEPTH = 1024;
  localparam int COORD_W = 32;
  localparam int SPEED_W = 24;
  localparam int ENTRY_W = 4 * COORD_W + SPEED_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_XYZ_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_E_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd5;
endpackage
`default_nettype wire

// ----- hw/rtl/linear_move_interpolator_top.sv -----
// Top level of the linear move interpolator: sequencer, shared multiplier,
// square root and divider steps. Depends on lmi_pkg and lmi_ram.
//
// Channel  | Ports                          | Transfer
// ---------+--------------------------------+-----------------------------
// input    | start, busy, in_*              | start high while busy low
// result   | out_valid, out_*               | one cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_*    | valid and ready both high
//
// Load, clear and any item on an empty table pass through the demand product
// to the result; a restart with entries first reads entry 0 from the table.
// A tick does differences, squares, step and the 33-step root, then decides
// (reading the next entry if due); each scaled axis adds a product and divide.
// Reset is synchronous and active low; the command table is not cleared,
// entries are read only once written. The receiver cannot stall results.
`default_nettype none
module linear_move_interpolator_top #(
  parameter int COMMAND_DEPTH = lmi_pkg::COMMAND_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_mode,
  input  wire logic signed [31:0]            in_cmd_x,
  input  wire logic signed [31:0]            in_cmd_y,
  input  wire logic signed [31:0]            in_cmd_z,
  input  wire logic signed [31:0]            in_cmd_e,
  input  wire logic [23:0]                   in_cmd_speed,
  input  wire logic [15:0]                   in_dt,
  output logic                               out_valid,
  output logic signed [31:0]                 out_nozzle_x,
  output logic signed [31:0]                 out_nozzle_y,
  output logic signed [31:0]                 out_nozzle_z,
  output logic signed [31:0]                 out_extruder_pos,
  output logic signed [31:0]                 out_extruder_demand,
  output logic [9:0]                         out_command_index,
  output logic                               out_last_reached,
  output logic                               out_load_rejected,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lmi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  localparam int IW = $clog2(COMMAND_DEPTH);
  localparam int CW = $clog2(COMMAND_DEPTH + 1);
  localparam int EW = (IW > 10) ? IW : 10;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_DIFF   = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_SQRT   = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_AMUL   = 4'd7;
  localparam logic [3:0] S_ADIV   = 4'd8;
  localparam logic [3:0] S_DMUL   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]  state_r;
  logic [5:0]  cnt_r;
  logic [1:0]  ax_r;

  // Configuration registers.
  logic [15:0]        xyz_thr_r, e_thr_r, flow_r;
  logic signed [31:0] org_x_r, org_y_r, org_z_r;

  // Motion state.
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      idx_r, rd_addr_r;
  logic [31:0]        pos_r [4];
  logic [31:0]        tgt_r [4];
  logic [23:0]        spd_r;
  logic [15:0]        dt_r;
  logic               rej_r;

  // Tick working registers.
  logic [32:0]        a_r [3];
  logic [3:0]         neg_r;
  logic [32:0]        ae_r;
  logic [65:0]        sum_r;
  logic [65:0]        rad_r;
  logic [35:0]        rem_r;
  logic [32:0]        root_r;
  logic [31:0]        step_r;
  logic [65:0]        mul_r;
  logic [32:0]        mul_a, mul_b;

  // Table memory.
  logic                ram_we;
  logic [lmi_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0]       ram_raddr;

  logic accept, full;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(COMMAND_DEPTH));
  assign busy   = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign ram_we    = accept && (in_mode == lmi_pkg::MODE_LOAD) && !full;
  assign ram_wdata = {in_cmd_x, in_cmd_y, in_cmd_z, in_cmd_e, in_cmd_speed};
  assign ram_raddr = rd_addr_r;

  lmi_ram #(
    .WIDTH (lmi_pkg::ENTRY_W),
    .DEPTH (COMMAND_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Index bookkeeping.
  logic [CW-1:0] idx_inc;
  logic          has_next;
  logic [EW-1:0] idx_ext;
  assign idx_inc  = CW'(idx_r) + CW'(1);
  assign has_next = (idx_inc < count_r);
  assign idx_ext  = EW'(idx_r);

  // The single multiplier is shared by the squares, the step, the axis
  // scaling and the extruder demand; its product is always registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        unique case (cnt_r[1:0])
          2'd0: begin mul_a = a_r[0]; mul_b = a_r[0]; end
          2'd1: begin mul_a = a_r[1]; mul_b = a_r[1]; end
          2'd2: begin mul_a = a_r[2]; mul_b = a_r[2]; end
          default: begin mul_a = 33'(spd_r); mul_b = 33'(dt_r); end
        endcase
      end
      S_AMUL: begin
        mul_a = a_r[ax_r];
        mul_b = 33'(step_r);
      end
      S_DMUL: begin
        mul_a = tgt_r[3][31] ? {1'b0, -tgt_r[3]} : {1'b0, tgt_r[3]};
        mul_b = 33'(flow_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Square root step: one result bit per cycle.
  logic [35:0] sq_remx, sq_trial;
  assign sq_remx  = {rem_r[33:0], rad_r[65:64]};
  assign sq_trial = {1'b0, root_r, 2'b01};

  // Division step: quotient bits shift into the low end of rad_r.
  logic [33:0] dv_remx;
  logic        dv_ge;
  logic [33:0] dv_diff;
  assign dv_remx = {rem_r[32:0], rad_r[32]};
  assign dv_ge   = (dv_remx >= {1'b0, root_r});
  assign dv_diff = dv_remx - {1'b0, root_r};

  // Done tests and the extrusion move.
  logic        xyz_near, e_done;
  logic [32:0] e_move;
  assign xyz_near = (root_r < 33'(xyz_thr_r));
  assign e_done   = (ae_r < 33'(e_thr_r));
  assign e_move   = (33'(step_r) < ae_r) ? 33'(step_r) : ae_r;

  // Extruder demand saturation.
  logic [39:0] pm;
  logic [31:0] demand;
  assign pm = mul_r[47:8];
  always_comb begin
    if (tgt_r[3][31]) begin
      demand = (pm > 40'h0080000000) ? 32'h80000000 : -pm[31:0];
    end else begin
      demand = (pm > 40'h007FFFFFFF) ? 32'h7FFFFFFF : pm[31:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      ax_r      <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      rd_addr_r <= '0;
      spd_r     <= '0;
      out_valid <= 1'b0;
      xyz_thr_r <= 16'd655;
      e_thr_r   <= 16'd7;
      flow_r    <= 16'd256;
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        pos_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lmi_pkg::REG_XYZ_THR:  xyz_thr_r <= cfg_data[15:0];
          lmi_pkg::REG_E_THR:    e_thr_r   <= cfg_data[15:0];
          lmi_pkg::REG_FLOW:     flow_r    <= cfg_data[15:0];
          lmi_pkg::REG_ORIGIN_X: org_x_r   <= cfg_data;
          lmi_pkg::REG_ORIGIN_Y: org_y_r   <= cfg_data;
          lmi_pkg::REG_ORIGIN_Z: org_z_r   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_mode)
              lmi_pkg::MODE_LOAD: begin
                if (!full) begin
                  count_r <= count_r + CW'(1);
                end
                state_r <= S_DMUL;
              end
              lmi_pkg::MODE_TICK: begin
                state_r <= (count_r == '0) ? S_DMUL : S_DIFF;
              end
              default: begin
                for (int i = 0; i < 4; i++) begin
                  pos_r[i] <= '0;
                end
                rd_addr_r <= '0;
                if (in_mode == lmi_pkg::MODE_CLEAR) begin
                  count_r <= '0;
                  idx_r   <= '0;
                  spd_r   <= '0;
                  for (int i = 0; i < 4; i++) begin
                    tgt_r[i] <= '0;
                  end
                  state_r <= S_DMUL;
                end else begin
                  state_r <= (count_r == '0) ? S_DMUL : S_RDWAIT;
                end
              end
            endcase
          end
        end
        S_RDWAIT: state_r <= S_LOAD;
        S_LOAD: begin
          tgt_r[0] <= ram_rdata[151:120];
          tgt_r[1] <= ram_rdata[119:88];
          tgt_r[2] <= ram_rdata[87:56];
          tgt_r[3] <= ram_rdata[55:24];
          spd_r    <= ram_rdata[23:0];
          idx_r    <= rd_addr_r;
          state_r  <= S_DMUL;
        end
        S_DIFF: begin
          cnt_r   <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (cnt_r == 6'd4) begin
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_SQRT: begin
          if (cnt_r == 6'd32) begin
            state_r <= S_DECIDE;
          end
          cnt_r <= cnt_r + 6'd1;
        end
        S_DECIDE: begin
          if (xyz_near && e_done) begin
            for (int i = 0; i < 4; i++) begin
              pos_r[i] <= tgt_r[i];
            end
            rd_addr_r <= idx_inc[IW-1:0];
            state_r   <= has_next ? S_RDWAIT : S_DMUL;
          end else begin
            if (!e_done && ae_r != '0) begin
              pos_r[3] <= neg_r[3] ? pos_r[3] - e_move[31:0] : pos_r[3] + e_move[31:0];
            end
            if (!xyz_near && root_r != '0) begin
              if (33'(step_r) >= root_r) begin
                for (int i = 0; i < 3; i++) begin
                  pos_r[i] <= tgt_r[i];
                end
                state_r <= S_DMUL;
              end else begin
                ax_r    <= '0;
                state_r <= S_AMUL;
              end
            end else begin
              state_r <= S_DMUL;
            end
          end
        end
        S_AMUL: begin
          cnt_r   <= '0;
          state_r <= S_ADIV;
        end
        S_ADIV: begin
          if (cnt_r == 6'd34) begin
            pos_r[ax_r] <= neg_r[ax_r] ? pos_r[ax_r] - rad_r[31:0]
                                       : pos_r[ax_r] + rad_r[31:0];
            if (ax_r == 2'd2) begin
              state_r <= S_DMUL;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_AMUL;
            end
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_DMUL: state_r <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  logic [32:0] dif [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dif[i] = {tgt_r[i][31], tgt_r[i]} - {pos_r[i][31], pos_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (accept) begin
      dt_r  <= in_dt;
      rej_r <= (in_mode == lmi_pkg::MODE_LOAD) && full;
    end
    unique case (state_r)
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= dif[i][32];
          a_r[i]   <= dif[i][32] ? -dif[i] : dif[i];
        end
        neg_r[3] <= dif[3][32];
        ae_r     <= dif[3][32] ? -dif[3] : dif[3];
        sum_r    <= '0;
      end
      S_SQ: begin
        if (cnt_r != 6'd0 && cnt_r != 6'd4) begin
          sum_r <= sum_r + mul_r;
        end
        if (cnt_r == 6'd4) begin
          step_r <= mul_r[39:8];
          rad_r  <= sum_r;
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      S_SQRT: begin
        rad_r <= {rad_r[63:0], 2'b00};
        if (sq_remx >= sq_trial) begin
          rem_r  <= sq_remx - sq_trial;
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= sq_remx;
          root_r <= {root_r[31:0], 1'b0};
        end
      end
      S_ADIV: begin
        // The scaled axis product is taken modulo 2^64 before the divide.
        if (cnt_r == 6'd0) begin
          rem_r <= {5'b00000, mul_r[63:33]};
          rad_r <= {33'd0, mul_r[32:0]};
        end else if (cnt_r != 6'd34) begin
          rem_r <= {3'b000, dv_ge ? dv_diff[32:0] : dv_remx[32:0]};
          rad_r <= {33'd0, rad_r[31:0], dv_ge};
        end
      end
      S_OUT: begin
        out_nozzle_x        <= pos_r[0] + org_x_r;
        out_nozzle_y        <= pos_r[1] + org_y_r;
        out_nozzle_z        <= pos_r[2] + org_z_r;
        out_extruder_pos    <= pos_r[3];
        out_extruder_demand <= demand;
        out_command_index   <= idx_ext[9:0];
        out_last_reached    <= (count_r != '0) && (idx_inc >= count_r);
        out_load_rejected   <= rej_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lmi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/lmi_checker.sv -----
// Port-level checks of the move interpolator, bound to its top level.
// Depends on linear_move_interpolator_top_assert.svh.
`default_nettype none
`include "linear_move_interpolator_top_assert.svh"
module lmi_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);
  // An accepted item makes the block busy.
  `LMI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  // A result appears only as the block frees up after its work.
  `LMI_ASSERT_NOW(a_result_after_work, out_valid, !busy && $past(busy), "result without work")
  // Each item yields one result strobe only.
  `LMI_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe repeated")
endmodule
bind linear_move_interpolator_top lmi_checker u_lmi_checker (.*);
`default_nettype wire

// ----- dv/tb_linear_move_interpolator_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of linear_move_interpolator_top: directed and random
// load, tick, restart and clear commands against a built-in motion predictor.
// Depends on lmi_pkg and the interpolator RTL.
`default_nettype none
module tb_linear_move_interpolator_top;
  localparam int DEPTH = lmi_pkg::COMMAND_DEPTH;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [lmi_pkg::CFG_IDX_W-1:0] REG_UNUSED = '1;

  // One result as the block reports it.
  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [31:0] epos;
    logic [31:0] demand;
    logic [9:0]  idx;
    logic        last;
    logic        rej;
  } nozzle_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = lmi_pkg::MODE_TICK;
  logic signed [31:0] in_cmd_x = '0, in_cmd_y = '0, in_cmd_z = '0, in_cmd_e = '0;
  logic [23:0] in_cmd_speed = '0;
  logic [15:0] in_dt = '0;
  logic out_valid;
  logic signed [31:0] out_nozzle_x, out_nozzle_y, out_nozzle_z;
  logic signed [31:0] out_extruder_pos, out_extruder_demand;
  logic [9:0] out_command_index;
  logic out_last_reached, out_load_rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lmi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  linear_move_interpolator_top i_dut (.*);

  always #5 clk = ~clk;

  // Predictor state: a copy of the command table, motion state and registers.
  longint tbl_x[DEPTH], tbl_y[DEPTH], tbl_z[DEPTH], tbl_e[DEPTH];
  longint tbl_spd[DEPTH];
  longint n_entries, act_idx, act_spd;
  longint pos[4], tgt[4];
  longint thr_xyz, thr_e, flow, org_x, org_y, org_z;

  nozzle_state_t expected_states[$];
  int errors = 0;
  longint cycles = 0;

  // Exact floor square root, one result bit per pass.
  function automatic longint unsigned floor_sqrt(logic [65:0] v);
    logic [67:0] rem, trial;
    logic [33:0] r;
    rem = '0;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = {r, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic void aim_at(longint i);
    tgt[0] = tbl_x[i];
    tgt[1] = tbl_y[i];
    tgt[2] = tbl_z[i];
    tgt[3] = tbl_e[i];
    act_spd = tbl_spd[i];
    act_idx = i;
  endfunction

  function automatic void advance_motion(longint dt);
    longint d[4];
    logic [65:0] sum;
    longint unsigned len, ae, stp, m, a;
    bit xyz_near, e_done;
    if (n_entries == 0) return;
    sum = '0;
    for (int i = 0; i < 4; i++) d[i] = tgt[i] - pos[i];
    for (int i = 0; i < 3; i++) begin
      a = d[i] < 0 ? -d[i] : d[i];
      sum = sum + 66'(a) * 66'(a);
    end
    len = floor_sqrt(sum);
    ae = d[3] < 0 ? -d[3] : d[3];
    xyz_near = len < thr_xyz;
    e_done = ae < thr_e;
    if (xyz_near && e_done) begin
      for (int i = 0; i < 4; i++) pos[i] = tgt[i];
      if (act_idx + 1 < n_entries) aim_at(act_idx + 1);
      return;
    end
    stp = (act_spd * dt) >> 8;
    if (!xyz_near && len > 0) begin
      for (int i = 0; i < 3; i++) begin
        a = d[i] < 0 ? -d[i] : d[i];
        m = stp >= len ? a : (a * stp) / len;
        pos[i] += d[i] < 0 ? -longint'(m) : longint'(m);
      end
    end
    if (!e_done && ae > 0) begin
      m = stp < ae ? stp : ae;
      pos[3] += d[3] < 0 ? -longint'(m) : longint'(m);
    end
  endfunction

  // Applies one command to the predictor and returns the state it reports.
  function automatic nozzle_state_t predict_nozzle(logic [1:0] mode, logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] e,
      logic [23:0] spd, logic [15:0] dt);
    nozzle_state_t r;
    longint unsigned pm;
    longint prod;
    bit rej;
    rej = 0;
    case (mode)
      lmi_pkg::MODE_LOAD: begin
        if (n_entries < DEPTH) begin
          tbl_x[n_entries] = x;
          tbl_y[n_entries] = y;
          tbl_z[n_entries] = z;
          tbl_e[n_entries] = e;
          tbl_spd[n_entries] = spd;
          n_entries++;
        end else begin
          rej = 1;
        end
      end
      lmi_pkg::MODE_TICK: advance_motion(dt);
      default: begin
        if (mode == lmi_pkg::MODE_CLEAR) begin
          n_entries = 0;
          for (int i = 0; i < 4; i++) tgt[i] = 0;
          act_spd = 0;
          act_idx = 0;
        end
        for (int i = 0; i < 4; i++) pos[i] = 0;
        if (n_entries > 0) aim_at(0);
      end
    endcase
    pm = ((tgt[3] < 0 ? -tgt[3] : tgt[3]) * flow) >> 8;
    if (pm > 64'h8000_0000) pm = 64'h8000_0000;
    if (tgt[3] < 0) begin
      prod = -longint'(pm);
    end else begin
      if (pm > 64'h7FFF_FFFF) pm = 64'h7FFF_FFFF;
      prod = pm;
    end
    r.nx = pos[0] + org_x;
    r.ny = pos[1] + org_y;
    r.nz = pos[2] + org_z;
    r.epos = pos[3];
    r.demand = prod;
    r.idx = act_idx;
    r.last = n_entries > 0 && act_idx + 1 >= n_entries;
    r.rej = rej;
    return r;
  endfunction

  // Random idle time before a transfer: mostly none or short, sometimes long.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ?
        $urandom_range(1, 3) : $urandom_range(10, 60));
    repeat (n) @(posedge clk);
  endtask

  // Sends one command; the prediction is queued at the accepting edge.
  task automatic send_command(logic [1:0] mode, logic signed [31:0] x = 0,
      logic signed [31:0] y = 0, logic signed [31:0] z = 0, logic signed [31:0] e = 0,
      logic [23:0] spd = 0, logic [15:0] dt = 0);
    idle_gap();
    in_mode <= mode;
    in_cmd_x <= x;
    in_cmd_y <= y;
    in_cmd_z <= z;
    in_cmd_e <= e;
    in_cmd_speed <= spd;
    in_dt <= dt;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_states.insert(expected_states.size(),
                           predict_nozzle(mode, x, y, z, e, spd, dt));
    start <= 1'b0;
    // The block is busy after a transfer, so this edge costs no throughput.
    @(posedge clk);
  endtask

  // Waits until every result is in, plus the longest operation.
  task automatic drain();
    while (expected_states.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [lmi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      lmi_pkg::REG_XYZ_THR:  thr_xyz = val[15:0];
      lmi_pkg::REG_E_THR:    thr_e = val[15:0];
      lmi_pkg::REG_FLOW:     flow = val[15:0];
      lmi_pkg::REG_ORIGIN_X: org_x = longint'(signed'(val));
      lmi_pkg::REG_ORIGIN_Y: org_y = longint'(signed'(val));
      lmi_pkg::REG_ORIGIN_Z: org_z = longint'(signed'(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Each result is compared field by field against the oldest prediction.
  always @(posedge clk) begin
    nozzle_state_t got, exp_s;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = {out_nozzle_x, out_nozzle_y, out_nozzle_z, out_extruder_pos,
             out_extruder_demand, out_command_index, out_last_reached, out_load_rejected};
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_s = expected_states.pop_front();
        if (got.nx !== exp_s.nx) begin
          $display("%0t: nozzle_x exp %h got %h", $time, exp_s.nx, got.nx); errors++;
        end
        if (got.ny !== exp_s.ny) begin
          $display("%0t: nozzle_y exp %h got %h", $time, exp_s.ny, got.ny); errors++;
        end
        if (got.nz !== exp_s.nz) begin
          $display("%0t: nozzle_z exp %h got %h", $time, exp_s.nz, got.nz); errors++;
        end
        if (got.epos !== exp_s.epos) begin
          $display("%0t: extruder_pos exp %h got %h", $time, exp_s.epos, got.epos); errors++;
        end
        if (got.demand !== exp_s.demand) begin
          $display("%0t: extruder_demand exp %h got %h", $time, exp_s.demand, got.demand);
          errors++;
        end
        if (got.idx !== exp_s.idx) begin
          $display("%0t: command_index exp %h got %h", $time, exp_s.idx, got.idx); errors++;
        end
        if (got.last !== exp_s.last) begin
          $display("%0t: last_reached exp %h got %h", $time, exp_s.last, got.last); errors++;
        end
        if (got.rej !== exp_s.rej) begin
          $display("%0t: load_rejected exp %h got %h", $time, exp_s.rej, got.rej); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Extremes of every field, every mode, full-table rejection, stale index.
  task automatic test_directed();
    send_command(lmi_pkg::MODE_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
    send_command(lmi_pkg::MODE_RESTART);
    send_command(lmi_pkg::MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 24'hFFFFFF, 0);
    send_command(lmi_pkg::MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 24'h000001, 0);
    send_command(lmi_pkg::MODE_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
    send_command(lmi_pkg::MODE_RESTART);
    repeat (6) send_command(lmi_pkg::MODE_TICK, 0, 0, 0, 0, 0, 16'hFFFF);
    send_command(lmi_pkg::MODE_TICK, 0, 0, 0, 0, 0, 0);
    send_command(lmi_pkg::MODE_CLEAR);
    send_command(lmi_pkg::MODE_TICK, 0, 0, 0, 0, 0, 16'h1234);
    // Fill the table to the brim and overflow it.
    for (int i = 0; i < DEPTH + 2; i++)
      send_command(lmi_pkg::MODE_LOAD, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), $urandom(), 0);
    send_command(lmi_pkg::MODE_RESTART);
    send_command(lmi_pkg::MODE_CLEAR);
  endtask

  // Short move programs followed by ticks, with some noise commands mixed in.
  task automatic test_random_moves(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int nload;
      logic [1:0] m;
      if ($urandom_range(0, 3) != 0) send_command(lmi_pkg::MODE_CLEAR);
      nload = $urandom_range(1, 5);
      for (int i = 0; i < nload; i++)
        send_command(lmi_pkg::MODE_LOAD, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(),
                     $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(256, 80000), 0);
      send_command(lmi_pkg::MODE_RESTART);
      sent += nload + 2;
      for (int i = $urandom_range(3, 25); i > 0; i--) begin
        m = $urandom_range(0, 9) == 0 ? 2'($urandom()) : lmi_pkg::MODE_TICK;
        send_command(m, rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom(),
                     $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 8000));
        sent++;
      end
    end
  endtask

  // Register phases, extremes among them, each followed by random moves.
  task automatic test_settings();
    write_reg(lmi_pkg::REG_XYZ_THR, 0);
    write_reg(lmi_pkg::REG_E_THR, 0);
    write_reg(lmi_pkg::REG_FLOW, 16'hFFFF);
    write_reg(lmi_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
    write_reg(lmi_pkg::REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(lmi_pkg::REG_ORIGIN_Z, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    test_random_moves(150);
    drain();
    write_reg(lmi_pkg::REG_XYZ_THR, 16'hFFFF);
    write_reg(lmi_pkg::REG_E_THR, 16'hFFFF);
    write_reg(lmi_pkg::REG_FLOW, 0);
    test_random_moves(150);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(lmi_pkg::REG_XYZ_THR, $urandom());
      write_reg(lmi_pkg::REG_E_THR, $urandom());
      write_reg(lmi_pkg::REG_FLOW, $urandom());
      write_reg(lmi_pkg::REG_ORIGIN_X, $urandom());
      write_reg(lmi_pkg::REG_ORIGIN_Y, $urandom());
      write_reg(lmi_pkg::REG_ORIGIN_Z, $urandom());
      test_random_moves(150);
      drain();
    end
  endtask

  initial begin
    n_entries = 0; act_idx = 0; act_spd = 0;
    for (int i = 0; i < 4; i++) begin
      pos[i] = 0;
      tgt[i] = 0;
    end
    thr_xyz = 655; thr_e = 7; flow = 256; org_x = 0; org_y = 0; org_z = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_moves(250);
    drain();
    test_settings();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
